@@ rtl/pcrc_pkg.sv @@
package pcrc_pkg;

    // Ring storage depth and derived widths
    localparam int MAX_SLOTS = 256;
    localparam int SLOT_W    = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;
    localparam int CFG_W     = 7;
    localparam int LEN_W     = ((SLOT_W > CFG_W + 1) ? SLOT_W : CFG_W + 1) + 2;
    localparam int FIELD_W   = 8;

    // Register index codes, decoded from paddr[2]
    localparam logic REG_PRE  = 1'b0;
    localparam logic REG_POST = 1'b1;

    // Write request into the trigger mark store
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic              mark;
    } mark_wr_t;

endpackage

@@ rtl/pcrc_marks.sv @@
module pcrc_marks
    import pcrc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  mark_wr_t          wr,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic              rd_mark
);

    logic              mark_mem [MAX_SLOTS];
    logic              rd_raw_reg;
    logic [SLOT_W-1:0] rd_addr_reg;
    logic              rd_vld_reg;
    logic              rd_hit_reg;
    logic              rd_fwd_reg;
    logic [SLOT_W:0]   fill_reg;
    logic              rd_data;

    // Store one mark per slot; read the slot checked by the next item
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mark_mem[wr.addr] <= wr.mark;
        end
        rd_raw_reg <= mark_mem[rd_addr];
    end

    // Track the written prefix of the ring; slots past it read as unmarked
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            rd_addr_reg <= '0;
            rd_vld_reg  <= 1'b0;
            rd_hit_reg  <= 1'b0;
            rd_fwd_reg  <= 1'b0;
        end else begin
            if (wr.en && ({1'b0, wr.addr} >= fill_reg)) begin
                fill_reg <= {1'b0, wr.addr} + (SLOT_W+1)'(1);
            end
            rd_addr_reg <= rd_addr;
            rd_vld_reg  <= ({1'b0, rd_addr} < fill_reg);
            rd_hit_reg  <= wr.en && (wr.addr == rd_addr);
            rd_fwd_reg  <= wr.mark;
        end
    end

    // Forward a mark written at the read edge or by the same item
    always_comb begin
        rd_data = rd_hit_reg ? rd_fwd_reg : (rd_vld_reg && rd_raw_reg);
        if (wr.en && (wr.addr == rd_addr_reg)) begin
            rd_mark = wr.mark;
        end else begin
            rd_mark = rd_data;
        end
    end

endmodule

@@ rtl/pretrigger_capture_ring_control_top.sv @@
// A result item is registered: it appears in the cycle after its input item is accepted.
// Throughput: one item per cycle; the result register frees while m_axis_tready is high.
// After a write to either register the next slot is re-reduced by the new ring
// length, one subtract a cycle, with s_axis_tready low.
// Reset (aresetn low, synchronous) clears the ring position, the unwritten range, both
// registers and the mark fill count; slots not written since read unmarked.
module pretrigger_capture_ring_control_top
    import pcrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] trigger_hit, [7:1] zero

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] write_slot, [15:8] dump_first, [23:16] dump_last
    output logic        m_axis_tuser    // [0] dump_now
);

    logic [CFG_W-1:0]  pre_reg, pre_next;
    logic [CFG_W-1:0]  post_reg, post_next;
    logic [LEN_W-1:0]  raw_reg, raw_next;
    logic [LEN_W-1:0]  base_reg, base_next;
    logic [SLOT_W-1:0] chk_reg, chk_next;
    logic              norm_busy_reg, norm_busy_next;
    logic              started_reg, started_next;
    logic [SLOT_W-1:0] us_reg, us_next;
    logic              uv_reg, uv_next;
    logic              ov_reg, ov_next;
    logic [FIELD_W-1:0] slot_out_reg, slot_out_next;
    logic [FIELD_W-1:0] first_out_reg, first_out_next;
    logic [FIELD_W-1:0] last_out_reg, last_out_next;
    logic              dump_out_reg, dump_out_next;

    logic              cfg_wr;
    logic              accept;
    logic [LEN_W-1:0]  len_sum;
    logic [LEN_W-1:0]  ring_n;
    logic [LEN_W-1:0]  cur_wide;
    logic [SLOT_W-1:0] cur_slot;
    logic [LEN_W-1:0]  cur_inc;
    logic [LEN_W-1:0]  oldest_wide;
    logic [LEN_W-1:0]  check_sum;
    logic [LEN_W-1:0]  check_wide;
    logic [LEN_W-1:0]  chk_inc;
    logic [LEN_W-1:0]  chk_adv;
    logic [SLOT_W-1:0] us_upd;
    logic              check_mark;
    logic              hit;
    mark_wr_t          mark_wr;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        pre_next  = pre_reg;
        post_next = post_reg;
        if (cfg_wr) begin
            case (paddr[2])
                REG_PRE:  pre_next  = pwdata[CFG_W-1:0];
                REG_POST: post_next = pwdata[CFG_W-1:0];
                default:  pre_next  = pre_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PRE:  prdata = 32'(pre_reg);
            REG_POST: prdata = 32'(post_reg);
            default:  prdata = '0;
        endcase
    end

    // Ring length, saturated at the storage depth
    assign len_sum = LEN_W'(pre_reg) + LEN_W'(post_reg) + LEN_W'(1);
    assign ring_n  = (len_sum > LEN_W'(MAX_SLOTS)) ? LEN_W'(MAX_SLOTS) : len_sum;

    // Handshake: hold input while re-reducing or while the result waits
    assign s_axis_tready = !norm_busy_reg && (!ov_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign hit           = s_axis_tdata[0];

    // Slot arithmetic; raw_reg never exceeds ring_n while accepting
    always_comb begin
        if (started_reg) begin
            cur_wide = (raw_reg >= ring_n) ? (raw_reg - ring_n) : raw_reg;
        end else begin
            cur_wide = '0;
        end
        cur_slot    = SLOT_W'(cur_wide);
        cur_inc     = cur_wide + LEN_W'(1);
        oldest_wide = (cur_inc >= ring_n) ? '0 : cur_inc;
        check_sum   = oldest_wide + LEN_W'(pre_reg);
        check_wide  = (check_sum >= ring_n) ? (check_sum - ring_n) : check_sum;
    end

    // Checked slot of the following item moves on by one slot with wrap
    assign chk_inc = LEN_W'(chk_reg) + LEN_W'(1);
    assign chk_adv = (chk_inc >= ring_n) ? '0 : chk_inc;

    // Mark write for this item; the first sample after reset is never marked
    assign mark_wr.en   = accept;
    assign mark_wr.addr = cur_slot;
    assign mark_wr.mark = started_reg && hit;

    pcrc_marks u_marks (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (mark_wr),
        .rd_addr (chk_next),
        .rd_mark (check_mark)
    );

    // Advance ring state and build the result item
    always_comb begin
        raw_next       = raw_reg;
        base_next      = base_reg;
        chk_next       = chk_reg;
        norm_busy_next = norm_busy_reg;
        started_next   = started_reg;
        us_next        = us_reg;
        uv_next        = uv_reg;
        ov_next        = ov_reg;
        slot_out_next  = slot_out_reg;
        first_out_next = first_out_reg;
        last_out_next  = last_out_reg;
        dump_out_next  = dump_out_reg;
        us_upd         = us_reg;

        // Re-reduce the next slot after a register change, then find its checked slot
        if (norm_busy_reg) begin
            if (raw_reg >= ring_n) begin
                raw_next = raw_reg - ring_n;
            end else begin
                norm_busy_next = 1'b0;
                chk_next       = SLOT_W'(check_wide);
            end
        end

        if (m_axis_tready) begin
            ov_next = 1'b0;
        end

        if (accept) begin
            raw_next     = cur_inc;
            base_next    = cur_inc;
            chk_next     = SLOT_W'(chk_adv);
            started_next = 1'b1;
            // Drop the overwritten slot from the unwritten range
            if (uv_reg && (us_reg == cur_slot)) begin
                us_upd = SLOT_W'(oldest_wide);
            end
            if (!uv_reg) begin
                us_upd = cur_slot;
            end
            us_next = us_upd;
            uv_next = 1'b1;

            ov_next       = 1'b1;
            slot_out_next = FIELD_W'(cur_slot);
            if (check_mark) begin
                dump_out_next  = 1'b1;
                first_out_next = FIELD_W'(us_upd);
                last_out_next  = FIELD_W'(cur_slot);
                uv_next        = 1'b0;
            end else begin
                dump_out_next  = 1'b0;
                first_out_next = '0;
                last_out_next  = '0;
            end
        end

        // Restart the reduction from the unreduced next slot
        if (cfg_wr) begin
            norm_busy_next = 1'b1;
            raw_next       = base_next;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_reg       <= '0;
            post_reg      <= '0;
            raw_reg       <= '0;
            base_reg      <= '0;
            chk_reg       <= '0;
            norm_busy_reg <= 1'b0;
            started_reg   <= 1'b0;
            us_reg        <= '0;
            uv_reg        <= 1'b0;
            ov_reg        <= 1'b0;
        end else begin
            pre_reg       <= pre_next;
            post_reg      <= post_next;
            raw_reg       <= raw_next;
            base_reg      <= base_next;
            chk_reg       <= chk_next;
            norm_busy_reg <= norm_busy_next;
            started_reg   <= started_next;
            us_reg        <= us_next;
            uv_reg        <= uv_next;
            ov_reg        <= ov_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        slot_out_reg  <= slot_out_next;
        first_out_reg <= first_out_next;
        last_out_reg  <= last_out_next;
        dump_out_reg  <= dump_out_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {last_out_reg, first_out_reg, slot_out_reg};
    assign m_axis_tuser  = dump_out_reg;

endmodule

@@ bench/pretrigger_capture_ring_control_checker.sv @@
module pretrigger_capture_ring_control_checker
    import pcrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] trigger_hit, [7:1] zero

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [7:0] write_slot, [15:8] dump_first, [23:16] dump_last
    input  logic        m_axis_tuser,   // [0] dump_now

    output int          fail_count,
    output int          pending_slots
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [FIELD_W-1:0] write_slot;
        logic               dump_now;
        logic [FIELD_W-1:0] dump_first;
        logic [FIELD_W-1:0] dump_last;
    } slot_result_t;

    slot_result_t     expected_slots[$];

    // Shadow copy of the ring control state
    logic [CFG_W-1:0] pre_cfg;
    logic [CFG_W-1:0] post_cfg;
    int unsigned      ring_pos;
    int unsigned      undumped_start;
    bit               undumped_valid;
    bit               ring_started;
    bit               hit_marks[MAX_SLOTS];

    // Advance the ring by one sample and work out the slot and dump range
    function automatic slot_result_t place_sample(input logic hit);
        int unsigned  ring_len;
        int unsigned  oldest;
        int unsigned  probe;
        slot_result_t res;
        ring_len = int'(pre_cfg) + int'(post_cfg) + 1;
        if (ring_len > MAX_SLOTS) begin
            ring_len = MAX_SLOTS;
        end
        ring_pos = ring_started ? (ring_pos + 1) % ring_len : 0;
        oldest   = (ring_pos + 1) % ring_len;
        if (undumped_valid && undumped_start == ring_pos) begin
            undumped_start = oldest;
        end
        if (!undumped_valid) begin
            undumped_start = ring_pos;
            undumped_valid = 1'b1;
        end
        hit_marks[ring_pos] = ring_started && hit;
        ring_started        = 1'b1;
        probe               = (oldest + int'(pre_cfg)) % ring_len;

        res.write_slot = ring_pos[FIELD_W-1:0];
        if (hit_marks[probe]) begin
            res.dump_now   = 1'b1;
            res.dump_first = undumped_start[FIELD_W-1:0];
            res.dump_last  = ring_pos[FIELD_W-1:0];
            undumped_valid = 1'b0;
        end else begin
            res.dump_now   = 1'b0;
            res.dump_first = '0;
            res.dump_last  = '0;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        slot_result_t want;
        slot_result_t got;
        if (!aresetn) begin
            pre_cfg        = '0;
            post_cfg       = '0;
            ring_pos       = 0;
            undumped_start = 0;
            undumped_valid = 1'b0;
            ring_started   = 1'b0;
            foreach (hit_marks[i]) begin
                hit_marks[i] = 1'b0;
            end
            expected_slots.delete();
        end else begin
            // Track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_PRE: begin
                        pre_cfg = pwdata[CFG_W-1:0];
                    end
                    REG_POST: begin
                        post_cfg = pwdata[CFG_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            // Compare each accepted result with the oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                got.write_slot = m_axis_tdata[7:0];
                got.dump_first = m_axis_tdata[15:8];
                got.dump_last  = m_axis_tdata[23:16];
                got.dump_now   = m_axis_tuser;
                if (expected_slots.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("unexpected item: slot=%0d dump=%0b first=%0d last=%0d",
                                 got.write_slot, got.dump_now, got.dump_first,
                                 got.dump_last);
                    end
                end else begin
                    want = expected_slots.pop_front();
                    if (got.write_slot !== want.write_slot || got.dump_now !== want.dump_now
                        || got.dump_first !== want.dump_first
                        || got.dump_last !== want.dump_last) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $write("mismatch: exp slot=%0d dump=%0b first=%0d last=%0d,",
                                   want.write_slot, want.dump_now, want.dump_first,
                                   want.dump_last);
                            $display(" got slot=%0d dump=%0b first=%0d last=%0d",
                                     got.write_slot, got.dump_now,
                                     got.dump_first, got.dump_last);
                        end
                    end
                end
            end

            // Predict the result of each accepted sample
            if (s_axis_tvalid && s_axis_tready) begin
                expected_slots.push_back(place_sample(s_axis_tdata[0]));
            end
        end
        pending_slots = expected_slots.size();
    end

endmodule

@@ bench/tb_pretrigger_capture_ring_control_top.sv @@
module tb_pretrigger_capture_ring_control_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pcrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_PHASES  = 11;
    localparam int PHASE_SAMPLES  = 48;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_e;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [0] trigger_hit, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [7:0] write_slot, [15:8] dump_first, [23:16] dump_last
    logic        m_axis_tuser;          // [0] dump_now

    int          fail_count;
    int          pending_slots;
    int          burst_left    = 0;
    int          idle_cycles   = 0;
    bit          hold_off_req  = 1'b0;

    pretrigger_capture_ring_control_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pretrigger_capture_ring_control_checker ring_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending_slots (pending_slots)
    );

    initial begin
        forever begin
            #1 aclk = ~aclk;
        end
    end

    // Write one register: setup phase, then access phase, then back to idle
    task automatic write_reg(input logic sel, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {{(32 - CFG_W){1'b0}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // Offer one sample, with bursts and random gaps on the input side
    task automatic send_sample(input logic hit);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, hit};
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain_ring;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (pending_slots != 0) begin
            @(negedge aclk);
        end
    endtask

    // Result side: stall on a changing pattern, or hold off for a long stretch
    initial begin
        rx_mode_e rx_mode;
        int       rx_left;
        rx_mode = RX_OPEN;
        rx_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end
            if (rx_left == 0) begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 80);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN: begin
                    m_axis_tready <= 1'b1;
                end
                RX_RANDOM: begin
                    m_axis_tready <= 1'($urandom_range(0, 1));
                end
                RX_SPARSE: begin
                    m_axis_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_axis_tready <= ((rx_left % 8) < 5);
                end
            endcase
        end
    end

    // Stop the run when nothing moves for too long
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        logic             hit_seq_b[12];
        logic             hit_seq_c[9];
        logic [CFG_W-1:0] pre_val;
        logic [CFG_W-1:0] post_val;
        int               density;
        int               sel;
        hit_seq_b = '{0, 0, 1, 0, 0, 0, 0, 1, 1, 0, 0, 0};
        hit_seq_c = '{1, 0, 0, 0, 1, 1, 0, 0, 1};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings give a one-slot ring; the first sample never marks
        send_sample(1'b1);
        send_sample(1'b1);
        send_sample(1'b0);
        send_sample(1'b1);
        drain_ring();

        // Small ring, triggers at known places
        write_reg(REG_PRE, 7'd2);
        write_reg(REG_POST, 7'd1);
        foreach (hit_seq_b[i]) begin
            send_sample(hit_seq_b[i]);
        end
        drain_ring();

        // Largest ring the registers allow
        write_reg(REG_PRE, 7'd127);
        write_reg(REG_POST, 7'd127);
        foreach (hit_seq_c[i]) begin
            send_sample(hit_seq_c[i]);
        end
        drain_ring();

        // Random phases, mostly small rings
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    pre_val  = 7'd127;
                    post_val = 7'd0;
                end
                1: begin
                    pre_val  = 7'd0;
                    post_val = 7'd127;
                end
                2: begin
                    pre_val  = 7'd0;
                    post_val = 7'd0;
                end
                default: begin
                    pre_val  = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom_range(0, 127))
                                                           : CFG_W'($urandom_range(0, 9));
                    post_val = CFG_W'($urandom_range(0, 9));
                end
            endcase
            sel = (phase < 3) ? 0 : $urandom_range(0, 3);
            if (sel != 2) begin
                write_reg(REG_PRE, pre_val);
            end
            if (sel != 1) begin
                write_reg(REG_POST, post_val);
            end
            case ($urandom_range(0, 3))
                0: density = 5;
                1: density = 25;
                2: density = 50;
                default: density = 90;
            endcase
            // Let the result side back up while samples keep coming
            if (phase == 4) begin
                hold_off_req = 1'b1;
            end
            repeat (PHASE_SAMPLES) begin
                send_sample($urandom_range(0, 99) < density);
            end
            drain_ring();
        end

        repeat (5) @(negedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
